### sv/hsv_to_rgb_converter_top_assert.svh
// ============================================================================
// HSV to RGB converter assertion macros
// Immediate-implication and fixed-latency checks clocked on clk, off in reset.
// ============================================================================
`ifndef HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH

`define HSVRGB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`define HSVRGB_ASSERT_AFTER(lbl, n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) else $error(msg);

`endif

### sv/hsvrgb_pkg.sv
// ============================================================================
// HSV to RGB converter package
// Field widths, fixed-point constants, sector codes and item types.
// ============================================================================
package hsvrgb_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int HUE_W         = 15;
	localparam int PCT_W         = 11;
	localparam int CH_W          = 8;
	localparam int POS_W         = 12;
	localparam int SV_PROD_W     = 22;
	localparam int LATENCY       = 7;

	localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
	localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
	localparam logic [HUE_W-1:0] HUE_BASE_2 = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_BASE_3 = 15'd11520;
	localparam logic [HUE_W-1:0] HUE_BASE_4 = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_BASE_5 = 15'd19200;
	localparam logic [PCT_W-1:0] PCT_FULL   = 11'd1600;

	localparam longint unsigned PCT_DEN    = 64'd1600;
	localparam longint unsigned CHROMA_DEN = 64'd2560000;
	localparam longint unsigned SECT_DEN   = 64'd15;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		logic    valid;
		sector_t sector;
	} ctl_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

endpackage

### sv/hsvrgb_front.sv
// ============================================================================
// HSV to RGB front end
// Limits the inputs, splits hue into sector and position, forms value and
// chroma as fractions. Three pipeline stages.
// ============================================================================
module hsvrgb_front #(
	parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  hsvrgb_pkg::hsv_t                  hsv,
	output hsvrgb_pkg::ctl_t                  ctl,
	output logic [FRAC_BITS:0]                chroma,
	output logic [FRAC_BITS:0]                value,
	output logic [hsvrgb_pkg::POS_W-1:0]      pos
);

	localparam int VF_SHIFT = 16;
	localparam int VF_RW    = FRAC_BITS + 6;
	localparam logic [VF_RW-1:0] VF_RECIP = VF_RW'(
		((64'd1 << (VF_SHIFT + FRAC_BITS)) + hsvrgb_pkg::PCT_DEN - 64'd1)
		/ hsvrgb_pkg::PCT_DEN);
	localparam int C_SHIFT = (FRAC_BITS >= 12) ? 31 : 43 - FRAC_BITS;
	localparam int C_RW    = C_SHIFT + FRAC_BITS - 21;
	localparam logic [C_RW-1:0] C_RECIP = C_RW'(
		((64'd1 << (C_SHIFT + FRAC_BITS)) + hsvrgb_pkg::CHROMA_DEN - 64'd1)
		/ hsvrgb_pkg::CHROMA_DEN);

	logic                              valid_s1;
	logic [hsvrgb_pkg::HUE_W-1:0]      hue_s1;
	logic [hsvrgb_pkg::PCT_W-1:0]      sat_s1;
	logic [hsvrgb_pkg::PCT_W-1:0]      val_s1;

	logic                              valid_s2;
	hsvrgb_pkg::sector_t               sector_s2;
	logic [hsvrgb_pkg::SV_PROD_W-1:0]  sv_s2;
	logic [FRAC_BITS:0]                vf_s2;
	logic [hsvrgb_pkg::POS_W-1:0]      pos_s2;

	logic                              valid_s3;
	hsvrgb_pkg::sector_t               sector_s3;
	logic [FRAC_BITS:0]                chroma_s3;
	logic [FRAC_BITS:0]                vf_s3;
	logic [hsvrgb_pkg::POS_W-1:0]      pos_s3;

	logic [hsvrgb_pkg::HUE_W-1:0]      hue_wrap;
	logic [hsvrgb_pkg::PCT_W-1:0]      sat_lim;
	logic [hsvrgb_pkg::PCT_W-1:0]      val_lim;
	hsvrgb_pkg::sector_t               sector;
	logic [hsvrgb_pkg::HUE_W-1:0]      sector_base;
	logic [hsvrgb_pkg::HUE_W-1:0]      hue_off;
	logic [hsvrgb_pkg::PCT_W+VF_RW-1:0] vf_prod;
	logic [hsvrgb_pkg::SV_PROD_W+C_RW-1:0] c_prod;
	logic                              odd_sector;
	logic [hsvrgb_pkg::HUE_W-1:0]      pos_mirror;

	// stage 1: wrap hue, limit percentages
	always_comb begin
		hue_wrap = (hsv.hue >= hsvrgb_pkg::HUE_FULL) ? hsv.hue - hsvrgb_pkg::HUE_FULL : hsv.hue;
		sat_lim  = (hsv.saturation > hsvrgb_pkg::PCT_FULL) ? hsvrgb_pkg::PCT_FULL
			: hsv.saturation;
		val_lim  = (hsv.brightness > hsvrgb_pkg::PCT_FULL) ? hsvrgb_pkg::PCT_FULL
			: hsv.brightness;
	end

	// stage 2: sector split, value fraction, saturation times value
	always_comb begin
		priority if (hue_s1 >= hsvrgb_pkg::HUE_BASE_5) begin
			sector      = hsvrgb_pkg::SEC_MAG_RED;
			sector_base = hsvrgb_pkg::HUE_BASE_5;
		end else if (hue_s1 >= hsvrgb_pkg::HUE_BASE_4) begin
			sector      = hsvrgb_pkg::SEC_BLU_MAG;
			sector_base = hsvrgb_pkg::HUE_BASE_4;
		end else if (hue_s1 >= hsvrgb_pkg::HUE_BASE_3) begin
			sector      = hsvrgb_pkg::SEC_CYN_BLU;
			sector_base = hsvrgb_pkg::HUE_BASE_3;
		end else if (hue_s1 >= hsvrgb_pkg::HUE_BASE_2) begin
			sector      = hsvrgb_pkg::SEC_GRN_CYN;
			sector_base = hsvrgb_pkg::HUE_BASE_2;
		end else if (hue_s1 >= hsvrgb_pkg::HUE_SECTOR) begin
			sector      = hsvrgb_pkg::SEC_YEL_GRN;
			sector_base = hsvrgb_pkg::HUE_SECTOR;
		end else begin
			sector      = hsvrgb_pkg::SEC_RED_YEL;
			sector_base = '0;
		end
		hue_off = hue_s1 - sector_base;
		vf_prod = (hsvrgb_pkg::PCT_W+VF_RW)'(val_s1) * (hsvrgb_pkg::PCT_W+VF_RW)'(VF_RECIP);
	end

	// stage 3: chroma fraction, mirror position in falling sectors
	always_comb begin
		c_prod = (hsvrgb_pkg::SV_PROD_W+C_RW)'(sv_s2)
			* (hsvrgb_pkg::SV_PROD_W+C_RW)'(C_RECIP);
		odd_sector = (sector_s2 == hsvrgb_pkg::SEC_YEL_GRN)
			|| (sector_s2 == hsvrgb_pkg::SEC_CYN_BLU)
			|| (sector_s2 == hsvrgb_pkg::SEC_MAG_RED);
		pos_mirror = hsvrgb_pkg::HUE_SECTOR - hsvrgb_pkg::HUE_W'(pos_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		hue_s1    <= hue_wrap;
		sat_s1    <= sat_lim;
		val_s1    <= val_lim;
		sector_s2 <= sector;
		sv_s2     <= hsvrgb_pkg::SV_PROD_W'(sat_s1) * hsvrgb_pkg::SV_PROD_W'(val_s1);
		vf_s2     <= vf_prod[VF_SHIFT +: FRAC_BITS+1];
		pos_s2    <= hue_off[hsvrgb_pkg::POS_W-1:0];
		sector_s3 <= sector_s2;
		chroma_s3 <= c_prod[C_SHIFT +: FRAC_BITS+1];
		vf_s3     <= vf_s2;
		pos_s3    <= odd_sector ? pos_mirror[hsvrgb_pkg::POS_W-1:0] : pos_s2;
	end

	assign ctl    = '{valid: valid_s3, sector: sector_s3};
	assign chroma = chroma_s3;
	assign value  = vf_s3;
	assign pos    = pos_s3;

endmodule

### sv/hsvrgb_chroma.sv
// ============================================================================
// HSV to RGB secondary term
// Forms the offset and the secondary term from chroma and sector position.
// Two pipeline stages.
// ============================================================================
module hsvrgb_chroma #(
	parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hsvrgb_pkg::ctl_t              ctl_in,
	input  logic [FRAC_BITS:0]            chroma_in,
	input  logic [FRAC_BITS:0]            value_in,
	input  logic [hsvrgb_pkg::POS_W-1:0]  pos_in,
	output hsvrgb_pkg::ctl_t              ctl,
	output logic [FRAC_BITS:0]            chroma,
	output logic [FRAC_BITS:0]            second,
	output logic [FRAC_BITS:0]            offset
);

	localparam int U_W  = FRAC_BITS + 1 + hsvrgb_pkg::POS_W;
	localparam int X_RW = FRAC_BITS + 5;
	localparam int X_SHIFT = FRAC_BITS + 8;
	localparam logic [X_RW-1:0] X_RECIP = X_RW'(
		((64'd1 << X_SHIFT) + hsvrgb_pkg::SECT_DEN - 64'd1) / hsvrgb_pkg::SECT_DEN);

	logic                   valid_s4;
	hsvrgb_pkg::sector_t    sector_s4;
	logic [U_W-1:0]         u_s4;
	logic [FRAC_BITS:0]     chroma_s4;
	logic [FRAC_BITS:0]     offset_s4;

	logic                   valid_s5;
	hsvrgb_pkg::sector_t    sector_s5;
	logic [FRAC_BITS:0]     chroma_s5;
	logic [FRAC_BITS:0]     second_s5;
	logic [FRAC_BITS:0]     offset_s5;

	logic [2*X_RW-1:0]      x_prod;

	// divide by 3840: drop 8 bits, then reciprocal of 15
	assign x_prod = (2*X_RW)'(u_s4[U_W-1:8]) * (2*X_RW)'(X_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= ctl_in.valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		sector_s4 <= ctl_in.sector;
		u_s4      <= U_W'(chroma_in) * U_W'(pos_in);
		chroma_s4 <= chroma_in;
		offset_s4 <= value_in - chroma_in;
		sector_s5 <= sector_s4;
		chroma_s5 <= chroma_s4;
		second_s5 <= x_prod[X_SHIFT +: FRAC_BITS+1];
		offset_s5 <= offset_s4;
	end

	assign ctl    = '{valid: valid_s5, sector: sector_s5};
	assign chroma = chroma_s5;
	assign second = second_s5;
	assign offset = offset_s5;

endmodule

### sv/hsvrgb_mix.sv
// ============================================================================
// HSV to RGB channel mix
// Routes chroma and secondary term by sector, adds the offset and scales
// each channel to eight bits. Two pipeline stages.
// ============================================================================
module hsvrgb_mix #(
	parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hsvrgb_pkg::ctl_t      ctl_in,
	input  logic [FRAC_BITS:0]    chroma_in,
	input  logic [FRAC_BITS:0]    second_in,
	input  logic [FRAC_BITS:0]    offset_in,
	output logic                  valid,
	output hsvrgb_pkg::rgb_t      rgb
);

	localparam int SC_W = FRAC_BITS + 9;

	logic                  valid_s6;
	logic [FRAC_BITS:0]    red_s6;
	logic [FRAC_BITS:0]    green_s6;
	logic [FRAC_BITS:0]    blue_s6;

	logic                  valid_s7;
	hsvrgb_pkg::rgb_t      rgb_s7;

	logic [FRAC_BITS:0]    red_t;
	logic [FRAC_BITS:0]    green_t;
	logic [FRAC_BITS:0]    blue_t;
	logic [SC_W-1:0]       red_sc;
	logic [SC_W-1:0]       green_sc;
	logic [SC_W-1:0]       blue_sc;

	always_comb begin
		unique case (ctl_in.sector)
			hsvrgb_pkg::SEC_RED_YEL: begin
				red_t = chroma_in; green_t = second_in; blue_t = '0;
			end
			hsvrgb_pkg::SEC_YEL_GRN: begin
				red_t = second_in; green_t = chroma_in; blue_t = '0;
			end
			hsvrgb_pkg::SEC_GRN_CYN: begin
				red_t = '0; green_t = chroma_in; blue_t = second_in;
			end
			hsvrgb_pkg::SEC_CYN_BLU: begin
				red_t = '0; green_t = second_in; blue_t = chroma_in;
			end
			hsvrgb_pkg::SEC_BLU_MAG: begin
				red_t = second_in; green_t = '0; blue_t = chroma_in;
			end
			default: begin
				red_t = chroma_in; green_t = '0; blue_t = second_in;
			end
		endcase
	end

	// times 255 as shift and subtract
	always_comb begin
		red_sc   = (SC_W'(red_s6) << 8) - SC_W'(red_s6);
		green_sc = (SC_W'(green_s6) << 8) - SC_W'(green_s6);
		blue_sc  = (SC_W'(blue_s6) << 8) - SC_W'(blue_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s6 <= ctl_in.valid;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		red_s6       <= red_t + offset_in;
		green_s6     <= green_t + offset_in;
		blue_s6      <= blue_t + offset_in;
		rgb_s7.red   <= red_sc[FRAC_BITS +: hsvrgb_pkg::CH_W];
		rgb_s7.green <= green_sc[FRAC_BITS +: hsvrgb_pkg::CH_W];
		rgb_s7.blue  <= blue_sc[FRAC_BITS +: hsvrgb_pkg::CH_W];
	end

	assign valid = valid_s7;
	assign rgb   = rgb_s7;

endmodule

### sv/hsv_to_rgb_converter_top.sv
// ============================================================================
// HSV to RGB converter
// Converts one HSV pixel into 8-bit RGB with the six-sector scheme.
// ============================================================================
//  channel  | ports                      | handshake
//  ---------+----------------------------+-------------------------------
//  input    | start, busy, hsv           | taken when start and not busy
//  result   | valid, rgb                 | one cycle strobe, no hold-off
//
// Seven register stages lie between an item being taken and its result.
// One item per clock, set by the fully pipelined datapath; busy stays low.
// Reset clears only the valid bits of the stages.
// The receiver cannot stall, so nothing is ever held back in the pipeline.
`include "hsv_to_rgb_converter_top_assert.svh"

module hsv_to_rgb_converter_top #(
	parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hsvrgb_pkg::hsv_t  hsv,
	output logic              valid,
	output hsvrgb_pkg::rgb_t  rgb
);

	localparam int SUM_W = FRAC_BITS + 2;
	localparam logic [SUM_W-1:0] ONE_FULL = SUM_W'(1) << FRAC_BITS;

	logic                             take;
	hsvrgb_pkg::ctl_t                 front_ctl;
	logic [FRAC_BITS:0]               front_chroma;
	logic [FRAC_BITS:0]               front_value;
	logic [hsvrgb_pkg::POS_W-1:0]     front_pos;
	hsvrgb_pkg::ctl_t                 mid_ctl;
	logic [FRAC_BITS:0]               mid_chroma;
	logic [FRAC_BITS:0]               mid_second;
	logic [FRAC_BITS:0]               mid_offset;

	assign busy = 1'b0;
	assign take = start & ~busy;

	hsvrgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (take),
		.hsv    (hsv),
		.ctl    (front_ctl),
		.chroma (front_chroma),
		.value  (front_value),
		.pos    (front_pos)
	);

	hsvrgb_chroma #(.FRAC_BITS(FRAC_BITS)) u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (front_ctl),
		.chroma_in (front_chroma),
		.value_in  (front_value),
		.pos_in    (front_pos),
		.ctl       (mid_ctl),
		.chroma    (mid_chroma),
		.second    (mid_second),
		.offset    (mid_offset)
	);

	hsvrgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (mid_ctl),
		.chroma_in (mid_chroma),
		.second_in (mid_second),
		.offset_in (mid_offset),
		.valid     (valid),
		.rgb       (rgb)
	);

	`HSVRGB_ASSERT_AFTER(a_latency, hsvrgb_pkg::LATENCY, take, valid, "result strobe missing")
	`HSVRGB_ASSERT_AFTER(a_black, hsvrgb_pkg::LATENCY, take && (hsv.brightness == '0), (rgb.red == '0) && (rgb.green == '0) && (rgb.blue == '0), "zero brightness not black")
	`HSVRGB_ASSERT_AFTER(a_gray, hsvrgb_pkg::LATENCY, take && (hsv.saturation == '0), (rgb.red == rgb.green) && (rgb.green == rgb.blue), "zero saturation not gray")
	`HSVRGB_ASSERT_NOW(a_offset, mid_ctl.valid, (SUM_W'(mid_chroma) + SUM_W'(mid_offset)) <= ONE_FULL, "chroma plus offset above one")

endmodule

### tb/hsv_rgb_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// HSV to RGB converter checker
// Watches the item and result channels, predicts each pixel's RGB value in
// fixed point and compares every result with the oldest pending prediction.
// ============================================================================
module hsv_rgb_checker
	import hsvrgb_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  hsv_t hsv,
	input  logic valid,
	input  rgb_t rgb,
	output int   fail_count,
	output int   pending_count,
	output int   checked_count
);

	typedef struct {
		hsv_t pixel;
		rgb_t color;
	} pixel_expect_t;

	pixel_expect_t rgb_expected_q[$];
	int fails = 0;
	int checked = 0;

	function automatic logic [CH_W-1:0] frac_to_byte(input longint unsigned frac);
		longint unsigned scaled;
		scaled = (frac * 64'd255) >> FRAC_BITS;
		return (scaled > 64'd255) ? 8'd255 : scaled[CH_W-1:0];
	endfunction

	function automatic rgb_t predict_rgb(input hsv_t pixel);
		longint unsigned h, s, v, one, vf, chroma, second, offset, pos, rise;
		longint unsigned red_f, green_f, blue_f;
		sector_t sector;
		rgb_t color;
		h = pixel.hue;
		s = (pixel.saturation > PCT_FULL) ? PCT_FULL : pixel.saturation;
		v = (pixel.brightness > PCT_FULL) ? PCT_FULL : pixel.brightness;
		if (h >= HUE_FULL)
			h = h - HUE_FULL;
		one    = 64'd1 << FRAC_BITS;
		vf     = (v * one) / PCT_DEN;
		chroma = (s * v * one) / CHROMA_DEN;
		sector = sector_t'(h / HUE_SECTOR);
		pos    = h % HUE_SECTOR;
		rise   = sector[0] ? (HUE_SECTOR - pos) : pos;
		second = (chroma * rise) / HUE_SECTOR;
		offset = vf - chroma;
		case (sector)
			SEC_RED_YEL: begin red_f = chroma; green_f = second; blue_f = 0;      end
			SEC_YEL_GRN: begin red_f = second; green_f = chroma; blue_f = 0;      end
			SEC_GRN_CYN: begin red_f = 0;      green_f = chroma; blue_f = second; end
			SEC_CYN_BLU: begin red_f = 0;      green_f = second; blue_f = chroma; end
			SEC_BLU_MAG: begin red_f = second; green_f = 0;      blue_f = chroma; end
			default:     begin red_f = chroma; green_f = 0;      blue_f = second; end
		endcase
		color.red   = frac_to_byte(red_f + offset);
		color.green = frac_to_byte(green_f + offset);
		color.blue  = frac_to_byte(blue_f + offset);
		return color;
	endfunction

	always @(posedge clk) begin
		pixel_expect_t want;
		if (arst_n) begin
			if (start && !busy) begin
				want.pixel = hsv;
				want.color = predict_rgb(hsv);
				rgb_expected_q = {rgb_expected_q, want};
			end
			if (valid) begin
				if (rgb_expected_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result %02h %02h %02h with no item pending",
							$realtime, rgb.red, rgb.green, rgb.blue);
				end else begin
					want = rgb_expected_q.pop_front();
					checked++;
					if (rgb.red !== want.color.red || rgb.green !== want.color.green ||
					    rgb.blue !== want.color.blue) begin
						fails++;
						if (fails <= 10)
							$display("%0t: hsv %0d/%0d/%0d expected rgb %0d %0d %0d, got %0d %0d %0d",
								$realtime, want.pixel.hue, want.pixel.saturation,
								want.pixel.brightness, want.color.red, want.color.green,
								want.color.blue, rgb.red, rgb.green, rgb.blue);
					end
				end
			end
		end
		fail_count <= fails;
		checked_count <= checked;
		pending_count <= rgb_expected_q.size();
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// HSV to RGB converter testbench
// Drives directed corner pixels, then random pixels in phases of sender
// idling, and reports the checker's verdict once every result has arrived.
// ============================================================================
module testbench;
	import hsvrgb_pkg::*;

	localparam int ITEMS_PER_PHASE = 375;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	hsv_t hsv;
	logic valid;
	rgb_t rgb;
	int   fail_count;
	int   pending_count;
	int   checked_count;
	int   items_sent;
	int   items_odd;

	hsv_to_rgb_converter_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.hsv    (hsv),
		.valid  (valid),
		.rgb    (rgb)
	);

	hsv_rgb_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.hsv           (hsv),
		.valid         (valid),
		.rgb           (rgb),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic hsv_t make_pixel(input int h, input int s, input int v);
		hsv_t pixel;
		pixel.hue        = h[HUE_W-1:0];
		pixel.saturation = s[PCT_W-1:0];
		pixel.brightness = v[PCT_W-1:0];
		return pixel;
	endfunction

	task automatic send_pixel(input hsv_t pixel, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		hsv   <= pixel;
		do @(posedge clk); while (busy);
		items_sent++;
		if (pixel.hue >= HUE_FULL || pixel.saturation > PCT_FULL || pixel.brightness > PCT_FULL)
			items_odd++;
	endtask

	task automatic drain_pipeline();
		start <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	initial begin
		int idle_pct[4];
		int s;
		int v;
		hsv_t corner_pixels[$];
		idle_pct = '{0, 52, 0, 7};
		items_sent = 0;
		items_odd = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		hsv    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		corner_pixels = '{
			make_pixel(0, 0, 0),         make_pixel(0, 1600, 1600),
			make_pixel(23039, 1600, 1600), make_pixel(23040, 1600, 1600),
			make_pixel(32767, 2047, 2047), make_pixel(3839, 1600, 1600),
			make_pixel(3840, 1600, 1600),  make_pixel(7680, 1600, 1600),
			make_pixel(11520, 1600, 1600), make_pixel(15360, 1600, 1600),
			make_pixel(19200, 1600, 1600), make_pixel(1920, 1600, 800),
			make_pixel(5760, 1200, 1600),  make_pixel(9600, 800, 1000),
			make_pixel(13440, 1600, 400),  make_pixel(17280, 400, 1600),
			make_pixel(21120, 1000, 1200), make_pixel(12000, 0, 1600),
			make_pixel(4000, 1601, 1601),  make_pixel(26000, 800, 1600),
			make_pixel(0, 2047, 0),        make_pixel(16384, 1024, 1024)
		};
		foreach (corner_pixels[i])
			send_pixel(corner_pixels[i], 0);
		drain_pipeline();

		for (int phase = 0; phase < 4; phase++) begin
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 85) begin
					s = $urandom_range(1600);
					v = $urandom_range(1600);
					if ($urandom_range(9) == 0)
						s = 1600;
					if ($urandom_range(9) == 0)
						v = 1600;
					send_pixel(make_pixel($urandom_range(23039), s, v), idle_pct[phase]);
				end else begin
					send_pixel(make_pixel($urandom_range(32767), $urandom_range(2047),
						$urandom_range(2047)), idle_pct[phase]);
				end
			end
			drain_pipeline();
		end

		repeat (LATENCY + 4) @(posedge clk);
		$display("Sent %0d pixels over four idle phases, %0d with wrapped hue or clamped percent.",
			items_sent, items_odd);
		$display("Checked %0d results, %0d mismatches.", checked_count, fail_count);
		if (fail_count == 0 && pending_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
